### hdl/mtrg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtrg_pkg
// Shared types, constants and the tempering function of the MT19937 generator.
// ----------------------------------------------------------------------------
package mtrg_pkg;

  localparam int unsigned TABLE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned TWIST_WRAP   = TABLE_WORDS - TWIST_OFFSET;
  localparam int unsigned ADDR_W       = $clog2(TABLE_WORDS);
  localparam int unsigned IDX_W        = $clog2(TABLE_WORDS + 2);
  localparam int unsigned DIV_STEPS    = 32;
  localparam int unsigned DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int unsigned APB_ADDR_W   = 4;

  localparam logic [IDX_W-1:0] UNSEEDED = IDX_W'(TABLE_WORDS + 1);

  localparam logic [31:0] MAT_A      = 32'h9908b0df;
  localparam logic [31:0] HI_BIT     = 32'h80000000;
  localparam logic [31:0] LO_BITS    = 32'h7fffffff;
  localparam logic [31:0] INIT_MULT  = 32'd1812433253;
  localparam logic [31:0] SEED_RESET = 32'd5489;
  localparam logic [31:0] TEMPER_B   = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C   = 32'hefc60000;
  localparam logic [31:0] RAW_SEL    = 32'hffffffff;

  typedef enum logic [1:0] {
    REG_SEED       = 2'd0,
    REG_RANGE_LOW  = 2'd1,
    REG_RANGE_HIGH = 2'd2
  } reg_idx_t;

  typedef enum logic {
    OP_DRAW   = 1'b0,
    OP_RESEED = 1'b1
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] remainder;
  } div_rsp_t;

  function automatic logic [31:0] temper(input logic [31:0] y_in);
    logic [31:0] y;
    y = y_in ^ (y_in >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage
`default_nettype wire

### hdl/mtrg_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtrg_front
// Request intake: classifies each transaction as draw or reseed and queues it.
// ----------------------------------------------------------------------------
module mtrg_front #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire logic          reseed,
  output logic               cmd_valid,
  input  wire logic          cmd_ready,
  output mtrg_pkg::cmd_t     cmd
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  mtrg_pkg::cmd_t   q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             seeded;
  logic             push;
  logic             pop;
  mtrg_pkg::cmd_t   cmd_in;

  assign req_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];
  assign push      = req_valid && req_ready;
  assign pop       = cmd_valid && cmd_ready;

  // first transaction after reset must seed the table
  always_comb begin
    cmd_in.op = (reseed || !seeded) ? mtrg_pkg::OP_RESEED : mtrg_pkg::OP_DRAW;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      seeded <= 1'b0;
    end else begin
      if (push) begin
        seeded <= 1'b1;
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/mtrg_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtrg_div
// Iterative restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module mtrg_div (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mtrg_pkg::div_req_t req,
  output mtrg_pkg::div_rsp_t  rsp
);

  logic                           busy;
  logic                           done;
  logic [mtrg_pkg::DIV_CNT_W-1:0] cnt;
  logic [31:0]                    rem;
  logic [31:0]                    dvd;
  logic [31:0]                    dsr;
  logic [31:0]                    rem_sh;
  logic [31:0]                    rem_step;

  // divisor stays below 2^31, so rem never uses its top bit
  assign rem_sh   = {rem[30:0], dvd[31]};
  assign rem_step = (rem_sh >= dsr) ? rem_sh - dsr : rem_sh;

  assign rsp.done      = done;
  assign rsp.remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= mtrg_pkg::DIV_CNT_W'(mtrg_pkg::DIV_STEPS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= rem_step;
      dvd <= dvd << 1;
    end
  end

  a_last_step_done: assert property (@(posedge clk) disable iff (rst)
    (busy && !req.start && cnt == '0) |=> (done && !busy))
    else $error("divider did not finish after its last step");

endmodule
`default_nettype wire

### hdl/mtrg_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtrg_back
// Table sequencer: seeding, twisting, drawing, tempering and range reduction.
// ----------------------------------------------------------------------------
module mtrg_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  output logic                     cmd_ready,
  input  wire mtrg_pkg::cmd_t      cmd,
  input  wire logic [31:0]         seed,
  input  wire logic signed [31:0]  range_low,
  input  wire logic signed [31:0]  range_high,
  output mtrg_pkg::div_req_t       div_req,
  input  wire mtrg_pkg::div_rsp_t  div_rsp,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output logic signed [31:0]       value
);

  localparam int unsigned AW = mtrg_pkg::ADDR_W;
  localparam int unsigned IW = mtrg_pkg::IDX_W;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_FILL_MUL = 12'b0000_0000_0010,
    S_FILL_WR  = 12'b0000_0000_0100,
    S_TW_INIT  = 12'b0000_0000_1000,
    S_TW_LOAD  = 12'b0000_0001_0000,
    S_TW_RD    = 12'b0000_0010_0000,
    S_TW_WR    = 12'b0000_0100_0000,
    S_DRAW_RD  = 12'b0000_1000_0000,
    S_TEMPER   = 12'b0001_0000_0000,
    S_REDUCE   = 12'b0010_0000_0000,
    S_DIV      = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_t;

  state_t         state;
  state_t         state_next;
  logic [IW-1:0]  idx;
  logic [AW-1:0]  k;
  logic [31:0]    prev;
  logic [31:0]    prod;
  logic [31:0]    cur;
  logic [31:0]    word;
  logic [31:0]    result;

  logic [31:0]    tbl [mtrg_pkg::TABLE_WORDS];
  logic           tbl_we;
  logic [AW-1:0]  tbl_waddr;
  logic [31:0]    tbl_wdata;
  logic [AW-1:0]  addr_a;
  logic [AW-1:0]  addr_b;
  logic [31:0]    rd_a;
  logic [31:0]    rd_b;

  logic           last_k;
  logic [AW-1:0]  k_succ;
  logic [AW-1:0]  k_far;
  logic [31:0]    fill_word;
  logic [31:0]    mix_y;
  logic [31:0]    twist_word;
  logic [31:0]    low_u;
  logic [31:0]    span;
  logic           raw_mode;
  logic           span_bad;
  logic           need_seed;
  logic           out_load;

  assign last_k    = (k == AW'(mtrg_pkg::TABLE_WORDS - 1));
  assign k_succ    = last_k ? '0 : k + 1'b1;
  assign k_far     = (k < AW'(mtrg_pkg::TWIST_WRAP)) ? k + AW'(mtrg_pkg::TWIST_OFFSET)
                                                     : k - AW'(mtrg_pkg::TWIST_WRAP);
  assign fill_word = prod + 32'(k);

  assign mix_y      = (cur & mtrg_pkg::HI_BIT) | (rd_a & mtrg_pkg::LO_BITS);
  assign twist_word = rd_b ^ (mix_y >> 1) ^ (mix_y[0] ? mtrg_pkg::MAT_A : 32'd0);

  assign low_u    = $unsigned(range_low);
  assign span     = $unsigned(range_high) - low_u + 32'd1;
  assign raw_mode = ($unsigned(range_low) == mtrg_pkg::RAW_SEL) &&
                    ($unsigned(range_high) == mtrg_pkg::RAW_SEL);
  assign span_bad = (span == 32'd0) || span[31];

  assign need_seed = (cmd.op == mtrg_pkg::OP_RESEED) ||
                     (idx > IW'(mtrg_pkg::TABLE_WORDS));
  assign out_load  = (state == S_DONE) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next       = state;
    cmd_ready        = 1'b0;
    tbl_we           = 1'b0;
    tbl_waddr        = k;
    tbl_wdata        = fill_word;
    addr_a           = k_succ;
    addr_b           = k_far;
    div_req.start    = 1'b0;
    div_req.dividend = word;
    div_req.divisor  = span;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_ready = 1'b1;
          if (need_seed) begin
            tbl_we     = 1'b1;
            tbl_waddr  = '0;
            tbl_wdata  = seed;
            state_next = S_FILL_MUL;
          end else if (idx == IW'(mtrg_pkg::TABLE_WORDS)) begin
            state_next = S_TW_INIT;
          end else begin
            state_next = S_DRAW_RD;
          end
        end
      end
      S_FILL_MUL: begin
        state_next = S_FILL_WR;
      end
      S_FILL_WR: begin
        tbl_we     = 1'b1;
        state_next = last_k ? S_TW_INIT : S_FILL_MUL;
      end
      S_TW_INIT: begin
        addr_a     = '0;
        state_next = S_TW_LOAD;
      end
      S_TW_LOAD: begin
        state_next = S_TW_RD;
      end
      S_TW_RD: begin
        state_next = S_TW_WR;
      end
      S_TW_WR: begin
        tbl_we     = 1'b1;
        tbl_wdata  = twist_word;
        state_next = last_k ? S_DRAW_RD : S_TW_RD;
      end
      S_DRAW_RD: begin
        addr_a     = idx[AW-1:0];
        state_next = S_TEMPER;
      end
      S_TEMPER: begin
        state_next = S_REDUCE;
      end
      S_REDUCE: begin
        if (raw_mode || span_bad) begin
          state_next = S_DONE;
        end else begin
          div_req.start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl[tbl_waddr] <= tbl_wdata;
    end
    rd_a <= tbl[addr_a];
    rd_b <= tbl[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= mtrg_pkg::UNSEEDED;
      k         <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && cmd_valid && need_seed) begin
        k <= AW'(1);
      end
      if (state == S_FILL_WR || state == S_TW_WR) begin
        k <= k_succ;
      end
      if (state == S_TW_INIT) begin
        k <= '0;
      end
      if (state == S_TW_WR && last_k) begin
        idx <= '0;
      end
      if (state == S_TEMPER) begin
        idx <= idx + 1'b1;
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      prev <= seed;
    end
    if (state == S_FILL_WR) begin
      prev <= fill_word;
    end
    if (state == S_FILL_MUL) begin
      prod <= mtrg_pkg::INIT_MULT * (prev ^ (prev >> 30));
    end
    if (state == S_TW_LOAD || state == S_TW_WR) begin
      cur <= rd_a;
    end
    if (state == S_TEMPER) begin
      word <= mtrg_pkg::temper(rd_a);
    end
    if (state == S_REDUCE) begin
      result <= raw_mode ? word : word + low_u;
    end
    if (state == S_DIV && div_rsp.done) begin
      result <= div_rsp.remainder + low_u;
    end
    if (out_load) begin
      value <= $signed(result);
    end
  end

  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    tbl_we |-> (tbl_waddr < AW'(mtrg_pkg::TABLE_WORDS)))
    else $error("table write outside the table");

  a_draw_seeded: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAW_RD) |-> (idx < IW'(mtrg_pkg::TABLE_WORDS)))
    else $error("draw from a table that is not twisted");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (rsp_valid && state == S_IDLE))
    else $error("finished result not presented");

  a_div_only_ranged: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> (!raw_mode && !span_bad))
    else $error("divider started on a raw or degenerate span");

endmodule
`default_nettype wire

### hdl/mt19937_ranged_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mt19937_ranged_generator
// MT19937 generator with optional reduction of each word into a range.
// ----------------------------------------------------------------------------
// Each request transaction (req_valid/req_ready, field reseed) yields exactly
// one response transaction (rsp_valid/rsp_ready, field value), in order.
// Registers on the APB port: 0x0 seed, 0x4 range_low, 0x8 range_high; both
// range registers at -1 give the raw tempered word. Write them only while idle.
// Requests land in a short queue, so new ones are taken while a response waits.
// Steps per request, in the table sequencer and the remainder unit:
//   raw output or degenerate span: table read, temper, output register
//   ranged output: the same, plus a pass through the bit-serial remainder unit
//   every 624th draw adds a table twist, word by word in a read and a write
//   state (one table write port and two registered read ports)
//   first request after reset or any reseed adds a fill of the table,
//   then the twist
// Reset empties the queue, drops any pending response and marks the table
// unseeded; the table itself is not cleared. A stalled receiver holds the
// response register and the back end waits, then the queue fills up.
// ----------------------------------------------------------------------------
module mt19937_ranged_generator #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  output logic                                   req_ready,
  input  wire logic                              reseed,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_ready,
  output logic signed [31:0]                     value,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [mtrg_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  logic               seed;
  logic [31:0]        seed_reg;
  logic signed [31:0] range_low;
  logic signed [31:0] range_high;
  logic               wr_en;
  mtrg_pkg::reg_idx_t reg_idx;

  logic               cmd_valid;
  logic               cmd_ready;
  mtrg_pkg::cmd_t     cmd;
  mtrg_pkg::div_req_t div_req;
  mtrg_pkg::div_rsp_t div_rsp;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = mtrg_pkg::reg_idx_t'(paddr[3:2]);
  assign seed    = reseed;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_reg   <= mtrg_pkg::SEED_RESET;
      range_low  <= $signed(mtrg_pkg::RAW_SEL);
      range_high <= $signed(mtrg_pkg::RAW_SEL);
    end else if (wr_en) begin
      unique case (reg_idx)
        mtrg_pkg::REG_SEED:       seed_reg   <= pwdata;
        mtrg_pkg::REG_RANGE_LOW:  range_low  <= $signed(pwdata);
        mtrg_pkg::REG_RANGE_HIGH: range_high <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mtrg_pkg::REG_SEED:       prdata = seed_reg;
      mtrg_pkg::REG_RANGE_LOW:  prdata = $unsigned(range_low);
      mtrg_pkg::REG_RANGE_HIGH: prdata = $unsigned(range_high);
      default:                  prdata = 32'd0;
    endcase
  end

  mtrg_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .reseed    (seed),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  mtrg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  mtrg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .seed       (seed_reg),
    .range_low  (range_low),
    .range_high (range_high),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .value      (value)
  );

endmodule
`default_nettype wire
